// File: src/kmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_pkg: shared definitions for the k-way merge / dedup core
// Widths, stream count, comparator tree node type and config decode.
// ----------------------------------------------------------------------------
package kmd_pkg;

    localparam int STREAMS  = 16;
    localparam int STREAM_W = $clog2(STREAMS);
    localparam int KEY_W    = 32;
    localparam int PAIR_W   = 2 * KEY_W;
    localparam int CFG_W    = 5;

    // One node of the minimum tree: lower stream index wins on equal keys.
    typedef struct packed {
        logic                vld;
        logic [PAIR_W-1:0]   key;
        logic [STREAM_W-1:0] idx;
    } kmd_node_t;

    // Decode active_streams into a per-stream enable mask.
    // Zero behaves as one, anything above STREAMS as STREAMS.
    function automatic logic [STREAMS-1:0] live_mask(input logic [CFG_W-1:0] cfg);
        logic [CFG_W-1:0]   n;
        logic [STREAMS-1:0] mask;
        n = cfg;
        if (n == '0)
        begin
            n = CFG_W'(1);
        end
        if (n > CFG_W'(STREAMS))
        begin
            n = CFG_W'(STREAMS);
        end
        for (int i = 0; i < STREAMS; i++)
        begin
            mask[i] = (CFG_W'(i) < n);
        end
        return mask;
    endfunction

endpackage

// File: src/kmd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd channel interfaces
// Valid/ready channels for config writes, input items and merge results.
// ----------------------------------------------------------------------------

interface kmd_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [kmd_pkg::CFG_W-1:0] active_streams;

    modport source (output valid, output active_streams, input ready);
    modport sink   (input valid, input active_streams, output ready);
endinterface

interface kmd_item_if;
    logic                        valid;
    logic                        ready;
    logic [kmd_pkg::STREAM_W-1:0] stream;
    logic [kmd_pkg::KEY_W-1:0]    key_high;
    logic [kmd_pkg::KEY_W-1:0]    key_low;
    logic                        stream_end;

    modport source (output valid, output stream, output key_high, output key_low,
                    output stream_end, input ready);
    modport sink   (input valid, input stream, input key_high, input key_low,
                    input stream_end, output ready);
endinterface

interface kmd_result_if;
    logic                        valid;
    logic                        ready;
    logic [kmd_pkg::KEY_W-1:0]    out_high;
    logic [kmd_pkg::KEY_W-1:0]    out_low;
    logic                        is_new;
    logic [kmd_pkg::STREAM_W-1:0] refill_stream;
    logic                        all_done;

    modport source (output valid, output out_high, output out_low, output is_new,
                    output refill_stream, output all_done, input ready);
    modport sink   (input valid, input out_high, input out_low, input is_new,
                    input refill_stream, input all_done, output ready);
endinterface

// File: src/kway_merge_dedup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_merge_dedup_core: k-way merge of sorted pair streams with dedup flag
// Holds one head per stream and pops the smallest once all live streams
// have a head or have ended.
// ----------------------------------------------------------------------------
// Usage:
//   cfg     : one write transaction sets active_streams (streams 0..n-1 take
//             part). Only write while no transaction is in flight. Always ready.
//   items   : one transaction per stream pair or end mark. Items for streams
//             that are inactive, already ended, or whose head is still held
//             are dropped (an end mark is still taken while a head is held).
//   results : at most one result per item: a popped pair with is_new and the
//             stream to refill, or once, the all_done marker with zero payload.
// Result: registered from the item transaction, shown on results in the cycle after it.
// Throughput: one item per cycle unless results stalls. Set by the path
//   from the item and the 16-leaf comparator tree into the result register.
// Stall: the result register parts the two sides; items is ready whenever
//   that register is empty or being drained this cycle, so a stalled
//   receiver holds at most one result and back-pressures items.
// Reset: heads and end flags cleared, active_streams = all streams,
//   dedup history empty, no result pending. Head data is not reset.
// ----------------------------------------------------------------------------
module kway_merge_dedup_core
(
    input  logic               clk,
    input  logic               rst_n,
    kmd_cfg_if.sink            cfg,
    kmd_item_if.sink           items,
    kmd_result_if.source       results
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [kmd_pkg::STREAMS-1:0] live_mask_reg;
    logic [kmd_pkg::STREAMS-1:0] head_valid_reg;
    logic [kmd_pkg::STREAMS-1:0] head_valid_next;
    logic [kmd_pkg::STREAMS-1:0] finished_reg;
    logic [kmd_pkg::STREAMS-1:0] finished_next;
    logic [kmd_pkg::KEY_W-1:0]   head_high_reg [kmd_pkg::STREAMS];
    logic [kmd_pkg::KEY_W-1:0]   head_low_reg  [kmd_pkg::STREAMS];
    logic [kmd_pkg::PAIR_W-1:0]  last_pair_reg;
    logic                        seen_any_reg;
    logic                        done_reported_reg;

    // Result register
    logic                         res_valid_reg;
    logic [kmd_pkg::KEY_W-1:0]    res_high_reg;
    logic [kmd_pkg::KEY_W-1:0]    res_low_reg;
    logic                         res_new_reg;
    logic [kmd_pkg::STREAM_W-1:0] res_stream_reg;
    logic                         res_done_reg;

    // ------------------------------------------------------------------
    // Item intake
    // ------------------------------------------------------------------
    logic                        item_acc;
    logic                        hit;
    logic                        head_wr;
    logic                        end_wr;
    logic [kmd_pkg::STREAMS-1:0] sel;
    logic [kmd_pkg::STREAMS-1:0] valid_eff;
    logic [kmd_pkg::STREAMS-1:0] fin_eff;
    logic                        all_ready;
    logic [kmd_pkg::PAIR_W-1:0]  in_key;

    assign items.ready = !res_valid_reg || results.ready;
    assign item_acc    = items.valid && items.ready;
    assign cfg.ready   = 1'b1;

    // Dropped: inactive stream, or stream already ended.
    assign hit     = item_acc && live_mask_reg[items.stream] && !finished_reg[items.stream];
    assign end_wr  = hit && items.stream_end;
    // A pair only lands if the stream's head slot is empty.
    assign head_wr = hit && !items.stream_end && !head_valid_reg[items.stream];
    assign sel     = {{(kmd_pkg::STREAMS-1){1'b0}}, 1'b1} << items.stream;
    assign in_key  = {items.key_high, items.key_low};

    assign valid_eff = head_valid_reg | (head_wr ? sel : '0);
    assign fin_eff   = finished_reg | (end_wr ? sel : '0);
    // Every live stream must hold a head or be ended before a pop.
    assign all_ready = &(valid_eff | fin_eff | ~live_mask_reg);

    // ------------------------------------------------------------------
    // Minimum tree over stored heads (heap layout, leaves at STREAMS+i).
    // The incoming pair is folded in afterwards so the tree runs off
    // registers only.
    // ------------------------------------------------------------------
    kmd_pkg::kmd_node_t node [1:2*kmd_pkg::STREAMS-1];
    kmd_pkg::kmd_node_t stored;

    always_comb
    begin
        for (int i = 0; i < kmd_pkg::STREAMS; i++)
        begin
            node[kmd_pkg::STREAMS+i].vld = head_valid_reg[i] && live_mask_reg[i];
            node[kmd_pkg::STREAMS+i].key = {head_high_reg[i], head_low_reg[i]};
            node[kmd_pkg::STREAMS+i].idx = kmd_pkg::STREAM_W'(i);
        end
        for (int k = kmd_pkg::STREAMS - 1; k >= 1; k--)
        begin
            // Right child wins only when strictly smaller (ties go low index).
            if (node[2*k+1].vld && (!node[2*k].vld || (node[2*k+1].key < node[2*k].key)))
            begin
                node[k] = node[2*k+1];
            end
            else
            begin
                node[k] = node[2*k];
            end
        end
    end

    assign stored = node[1];

    logic                         take_in;
    logic                         any_head;
    logic [kmd_pkg::PAIR_W-1:0]   best_key;
    logic [kmd_pkg::STREAM_W-1:0] best_idx;
    logic                         pop;
    logic                         fin_evt;
    logic                         emit;

    assign take_in  = head_wr && (!stored.vld || (in_key < stored.key) ||
                      ((in_key == stored.key) && (items.stream < stored.idx)));
    assign any_head = stored.vld || head_wr;
    assign best_key = take_in ? in_key : stored.key;
    assign best_idx = take_in ? items.stream : stored.idx;

    assign pop     = item_acc && all_ready && any_head;
    assign fin_evt = item_acc && all_ready && !any_head && !done_reported_reg;
    assign emit    = pop || fin_evt;

    always_comb
    begin
        head_valid_next = valid_eff;
        if (pop)
        begin
            head_valid_next[best_idx] = 1'b0;
        end
        finished_next = fin_eff;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_mask_reg     <= '1;
            head_valid_reg    <= '0;
            finished_reg      <= '0;
            last_pair_reg     <= '0;
            seen_any_reg      <= 1'b0;
            done_reported_reg <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                live_mask_reg <= kmd_pkg::live_mask(cfg.active_streams);
            end
            head_valid_reg <= head_valid_next;
            finished_reg   <= finished_next;
            if (pop)
            begin
                last_pair_reg <= best_key;
                seen_any_reg  <= 1'b1;
            end
            if (fin_evt)
            begin
                done_reported_reg <= 1'b1;
            end
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Head storage and result payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (head_wr)
        begin
            head_high_reg[items.stream] <= items.key_high;
            head_low_reg[items.stream]  <= items.key_low;
        end
        if (emit)
        begin
            res_high_reg   <= pop ? best_key[kmd_pkg::PAIR_W-1:kmd_pkg::KEY_W] : '0;
            res_low_reg    <= pop ? best_key[kmd_pkg::KEY_W-1:0] : '0;
            res_new_reg    <= pop && (!seen_any_reg || (best_key != last_pair_reg));
            res_stream_reg <= pop ? best_idx : '0;
            res_done_reg   <= fin_evt;
        end
    end

    assign results.valid         = res_valid_reg;
    assign results.out_high      = res_high_reg;
    assign results.out_low       = res_low_reg;
    assign results.is_new        = res_new_reg;
    assign results.refill_stream = res_stream_reg;
    assign results.all_done      = res_done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Completion marker carries an all-zero payload.
    a_done_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_done_reg) |->
            (res_high_reg == '0 && res_low_reg == '0 && !res_new_reg && res_stream_reg == '0))
        else $error("completion result with nonzero payload");

    // A popped stream's head slot is empty afterwards.
    a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !head_valid_reg[$past(best_idx)])
        else $error("popped head still valid");

    // Completion is reported only once.
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reported_reg |-> !fin_evt)
        else $error("second completion result");

    // A pop and a completion never coincide.
    a_pop_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (res_valid_reg && (res_done_reg != $past(pop))))
        else $error("result kind mismatch");

endmodule

// File: tb/kway_merge_dedup_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_merge_dedup_core_tb: self-checking bench for the k-way merge core
// Drives sorted pair streams (plus noise and end marks) into the core, predicts
// every popped pair, dedup flag, refill request and the completion marker, and
// checks each result transaction in order, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module kway_merge_dedup_core_tb;

    // One input transaction and one result transaction, at the core's widths.
    typedef struct packed {
        logic [kmd_pkg::STREAM_W-1:0] stream;
        logic [kmd_pkg::KEY_W-1:0]    key_high;
        logic [kmd_pkg::KEY_W-1:0]    key_low;
        logic                         stream_end;
    } pair_item_t;

    typedef struct packed {
        logic [kmd_pkg::KEY_W-1:0]    out_high;
        logic [kmd_pkg::KEY_W-1:0]    out_low;
        logic                         is_new;
        logic [kmd_pkg::STREAM_W-1:0] refill_stream;
        logic                         all_done;
    } merge_out_t;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 3;   // core answers in the cycle after the item
    localparam int HOLD_CYCLES    = 60;  // long receiver hold-off for back-pressure
    localparam int PHASE_GOAL     = 46;  // effective items per random phase

    // Opening heads for the first merge: extremes, ties and exact duplicates.
    localparam logic [kmd_pkg::PAIR_W-1:0] CORNER_PAIRS [kmd_pkg::STREAMS] = '{
        64'h0000_0000_0000_0000,   // equals the cleared history, still new
        64'h0000_0000_0000_0000,   // duplicate of stream 0, loses the tie
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0001_0000_0000,
        64'h0000_0000_FFFF_FFFF,   // same major key, minor key decides
        64'h8000_0000_0000_0001,
        64'h0000_0001_0000_0000,   // duplicate of stream 3
        64'h7FFF_FFFF_FFFF_FFFF,
        64'hAAAA_AAAA_5555_5555,
        64'h5555_5555_AAAA_AAAA,
        64'hFFFF_FFFF_FFFF_FFFE,
        64'h0000_0000_0000_0001,
        64'h0000_0002_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,   // duplicate of stream 2 at the very top
        64'h0000_1234_0000_5678,
        64'hFFFF_FFFF_0000_0000
    };

    logic clk;
    logic rst_n;

    kmd_cfg_if    cfg_bus ();
    kmd_item_if   item_bus ();
    kmd_result_if result_bus ();

    kway_merge_dedup_core uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .items   (item_bus),
        .results (result_bus)
    );

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the core's heads, end flags, dedup
    // history and the active_streams register.
    // ------------------------------------------------------------------------
    logic [kmd_pkg::PAIR_W-1:0] head_key      [kmd_pkg::STREAMS];
    bit                         head_held     [kmd_pkg::STREAMS];
    bit                         stream_closed [kmd_pkg::STREAMS];
    logic [kmd_pkg::PAIR_W-1:0] prev_pair = '0;
    bit                         any_popped = 1'b0;
    bit                         done_sent = 1'b0;
    logic [kmd_pkg::CFG_W-1:0]  cfg_streams = kmd_pkg::CFG_W'(kmd_pkg::STREAMS);

    // Per-stream position of the ascending sequence generator.
    logic [kmd_pkg::PAIR_W-1:0] stream_cursor [kmd_pkg::STREAMS];

    merge_out_t expected_merge [$];

    // Bench knobs and bookkeeping.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int errors         = 0;
    int items_sent     = 0;
    int items_took     = 0;
    int results_seen   = 0;
    int dup_seen       = 0;
    int done_seen      = 0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Out-of-range register values clamp: zero acts as one, above STREAMS
    // acts as STREAMS.
    function automatic int unsigned live_streams();
        int unsigned n;
        n = 32'(cfg_streams);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > kmd_pkg::STREAMS)
        begin
            n = kmd_pkg::STREAMS;
        end
        return n;
    endfunction

    // Apply one accepted item, then pop the smallest head if every live stream
    // holds a head or has ended. took = the item changed state or gave a result.
    function automatic void merge_step(input pair_item_t it, output merge_out_t res,
                                       output bit emit, output bit took);
        int unsigned                n;
        bit                         all_ready;
        bit                         any_head;
        int                         best;
        logic [kmd_pkg::PAIR_W-1:0] best_key;
        n         = live_streams();
        all_ready = 1'b1;
        any_head  = 1'b0;
        best      = -1;
        best_key  = '0;
        res       = '0;
        emit      = 1'b0;
        took      = 1'b0;

        // Inactive or ended streams drop the item; a pair for a held head is
        // dropped too, but an end mark still lands.
        if (it.stream < n && !stream_closed[it.stream])
        begin
            if (it.stream_end)
            begin
                stream_closed[it.stream] = 1'b1;
                took = 1'b1;
            end
            else if (!head_held[it.stream])
            begin
                head_key[it.stream]  = {it.key_high, it.key_low};
                head_held[it.stream] = 1'b1;
                took = 1'b1;
            end
        end

        // Strict less-than keeps the lowest stream on equal keys.
        for (int unsigned i = 0; i < n; i++)
        begin
            if (head_held[i])
            begin
                any_head = 1'b1;
                if (best < 0 || head_key[i] < best_key)
                begin
                    best     = int'(i);
                    best_key = head_key[i];
                end
            end
            else if (!stream_closed[i])
            begin
                all_ready = 1'b0;
            end
        end

        if (!all_ready)
        begin
            return;
        end

        if (any_head)
        begin
            res.out_high      = best_key[kmd_pkg::PAIR_W-1:kmd_pkg::KEY_W];
            res.out_low       = best_key[kmd_pkg::KEY_W-1:0];
            res.is_new        = !any_popped || (best_key != prev_pair);
            res.refill_stream = kmd_pkg::STREAM_W'(best);
            head_held[best]   = 1'b0;
            prev_pair         = best_key;
            any_popped        = 1'b1;
            emit              = 1'b1;
            took              = 1'b1;
        end
        else if (!done_sent)
        begin
            // Everything ended and drained: one completion marker, zero payload.
            res.all_done = 1'b1;
            done_sent    = 1'b1;
            emit         = 1'b1;
            took         = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    function automatic pair_item_t make_item(input int unsigned s,
                                             input logic [kmd_pkg::PAIR_W-1:0] pair,
                                             input logic fin);
        pair_item_t it;
        it.stream     = kmd_pkg::STREAM_W'(s);
        it.key_high   = pair[kmd_pkg::PAIR_W-1:kmd_pkg::KEY_W];
        it.key_low    = pair[kmd_pkg::KEY_W-1:0];
        it.stream_end = fin;
        return it;
    endfunction

    // Next pair of a well-formed merge: feed a stream that was asked for a
    // refill. Keys climb per stream, often repeat, and sometimes jump to
    // another stream's position so cross-stream duplicates come up.
    function automatic pair_item_t next_in_order();
        int unsigned                n;
        int unsigned                needy [$];
        int unsigned                held  [$];
        int unsigned                s;
        int unsigned                other;
        logic [kmd_pkg::PAIR_W-1:0] stride;
        n = live_streams();
        for (int unsigned i = 0; i < n; i++)
        begin
            if (!stream_closed[i] && !head_held[i])
            begin
                needy = {needy, i};
            end
            else if (head_held[i])
            begin
                held = {held, i};
            end
        end
        if (needy.size() > 0)
        begin
            s = needy[$urandom_range(needy.size() - 1)];
        end
        else if (held.size() > 0)
        begin
            // all heads present: a dropped pair still lets the pop happen
            s = held[$urandom_range(held.size() - 1)];
        end
        else
        begin
            s = $urandom_range(kmd_pkg::STREAMS - 1);
        end

        case ($urandom_range(9))
            0, 1:       stride = '0;
            2, 3, 4, 5: stride = kmd_pkg::PAIR_W'($urandom_range(3));
            default:    stride = {$urandom, $urandom} >> $urandom_range(40, 12);
        endcase
        other = $urandom_range(kmd_pkg::STREAMS - 1);
        if (stream_cursor[s][kmd_pkg::PAIR_W-1:kmd_pkg::PAIR_W-4] != '0)
        begin
            stream_cursor[s] = kmd_pkg::PAIR_W'($urandom_range(255));
        end
        else if ($urandom_range(3) == 0 && stream_cursor[other] > stream_cursor[s])
        begin
            stream_cursor[s] = stream_cursor[other];
        end
        else
        begin
            stream_cursor[s] = stream_cursor[s] + stride;
        end
        return make_item(s, stream_cursor[s], 1'b0);
    endfunction

    // Noise: any stream, full-range keys; end marks only where they are dropped.
    function automatic pair_item_t noise_item();
        pair_item_t it;
        it.stream     = kmd_pkg::STREAM_W'($urandom_range(kmd_pkg::STREAMS - 1));
        it.key_high   = $urandom;
        it.key_low    = $urandom;
        it.stream_end = (it.stream >= live_streams()) ? 1'($urandom_range(1)) : 1'b0;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers (inputs change on the falling edge)
    // ------------------------------------------------------------------------

    // One item transaction. Entered and left just after a falling edge; valid
    // stays up into the next item unless an idle cycle is drawn.
    task automatic send_item(input pair_item_t it, output bit took);
        merge_out_t res;
        bit         emit;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.stream     <= it.stream;
        item_bus.key_high   <= it.key_high;
        item_bus.key_low    <= it.key_low;
        item_bus.stream_end <= it.stream_end;
        do
            @(posedge clk);
        while (!item_bus.ready);
        merge_step(it, res, emit, took);
        if (emit)
        begin
            expected_merge = {expected_merge, res};
        end
        items_sent++;
        if (took)
        begin
            items_took++;
        end
        @(negedge clk);
    endtask

    // Register writes only with the core idle: input quiet, every predicted
    // result drained, and a short pause for an item that gave no result.
    task automatic settle_and_configure(input logic [kmd_pkg::CFG_W-1:0] value);
        item_bus.valid <= 1'b0;
        while (expected_merge.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_bus.valid          <= 1'b1;
        cfg_bus.active_streams <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_streams = value;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly well-formed merge traffic, some noise; runs until enough items
    // have actually done something.
    task automatic run_random_phase(input logic [kmd_pkg::CFG_W-1:0] value, input int s_idle,
                                    input int r_stall, input int goal);
        pair_item_t it;
        bit         took;
        int         got;
        settle_and_configure(value);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        got = 0;
        while (got < goal)
        begin
            if ($urandom_range(99) < 85)
            begin
                it = next_in_order();
            end
            else
            begin
                it = noise_item();
            end
            send_item(it, took);
            if (took)
            begin
                got++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // All sixteen streams at reset width: corner heads, first pop against the
    // cleared history, a refill equal to the popped pair, a pair for a held head.
    task automatic test_merge_basics();
        bit took;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int unsigned s = 0; s < kmd_pkg::STREAMS; s++)
        begin
            send_item(make_item(s, CORNER_PAIRS[s], 1'b0), took);
            stream_cursor[s] = CORNER_PAIRS[s];
        end
        // stream 0 was popped; send the same pair again, then the next one
        send_item(make_item(0, CORNER_PAIRS[0], 1'b0), took);
        send_item(make_item(0, 64'h0000_0000_0000_0001, 1'b0), took);
        // stream 5 still holds its head, so this pair is dropped
        send_item(make_item(5, 64'h0000_0000_0000_0000, 1'b0), took);
        send_item(next_in_order(), took);
    endtask

    // Register extremes: zero clamps to one stream, large values clamp to all.
    task automatic test_config_extremes();
        bit took;
        settle_and_configure(kmd_pkg::CFG_W'(0));
        send_item(make_item(9, 64'h0000_0005_0000_0005, 1'b0), took);  // inactive
        send_item(make_item(12, '1, 1'b1), took);                       // inactive end mark
        send_item(next_in_order(), took);
        send_item(next_in_order(), took);
        settle_and_configure(kmd_pkg::CFG_W'(31));
        send_item(next_in_order(), took);
        settle_and_configure(kmd_pkg::CFG_W'(17));
        send_item(next_in_order(), took);
    endtask

    // Random traffic across register settings and idle/stall mixes.
    task automatic test_random_traffic();
        run_random_phase(kmd_pkg::CFG_W'(16), 0, 0, PHASE_GOAL);
        run_random_phase(kmd_pkg::CFG_W'(5), 0, 0, PHASE_GOAL);
        run_random_phase(kmd_pkg::CFG_W'(31), 69, 0, PHASE_GOAL);
        run_random_phase(kmd_pkg::CFG_W'(2), 69, 0, PHASE_GOAL);
        run_random_phase(kmd_pkg::CFG_W'(1), 0, 69, PHASE_GOAL);
        run_random_phase(kmd_pkg::CFG_W'(12), 0, 69, PHASE_GOAL);
        run_random_phase(kmd_pkg::CFG_W'(0), 19, 19, PHASE_GOAL);
        run_random_phase(kmd_pkg::CFG_W'(16), 19, 19, PHASE_GOAL);
    endtask

    // Receiver holds off for a long stretch while items keep coming, so the
    // result register fills and the core stops taking items.
    task automatic test_backpressure();
        bit took;
        settle_and_configure(kmd_pkg::CFG_W'(16));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
        repeat (20)
        begin
            send_item(next_in_order(), took);
        end
    endtask

    // End streams 0..2 (held heads first), drain the rest with items for
    // ended streams, get the one completion marker, then widen the merge and
    // keep going: pops continue but no second marker comes.
    task automatic test_completion();
        bit took;
        settle_and_configure(kmd_pkg::CFG_W'(3));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int pass = 0; pass < 2; pass++)
        begin
            for (int unsigned s = 0; s < 3; s++)
            begin
                if (!stream_closed[s] && (head_held[s] || pass == 1))
                begin
                    send_item(make_item(s, {$urandom, $urandom}, 1'b1), took);
                end
            end
        end
        while (!done_sent)
        begin
            send_item(make_item(1, 64'h0000_0000_0000_0007, 1'b0), took);
        end
        send_item(make_item(0, '1, 1'b0), took);
        send_item(make_item(2, '0, 1'b1), took);
        run_random_phase(kmd_pkg::CFG_W'(16), 19, 19, 30);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready drawn per cycle, or forced low during a hold-off.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_bus.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        merge_out_t want;
        merge_out_t got;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got.out_high      = result_bus.out_high;
            got.out_low       = result_bus.out_low;
            got.is_new        = result_bus.is_new;
            got.refill_stream = result_bus.refill_stream;
            got.all_done      = result_bus.all_done;
            results_seen++;
            if (expected_merge.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result high=%h low=%h new=%b refill=%0d done=%b",
                         $time, got.out_high, got.out_low, got.is_new,
                         got.refill_stream, got.all_done);
            end
            else
            begin
                want = expected_merge.pop_front();
                if (want.all_done)
                begin
                    done_seen++;
                end
                else if (!want.is_new)
                begin
                    dup_seen++;
                end
                if (got.out_high !== want.out_high || got.out_low !== want.out_low ||
                    got.is_new !== want.is_new || got.refill_stream !== want.refill_stream ||
                    got.all_done !== want.all_done)
                begin
                    errors++;
                    $display("%0t: mismatch expected high=%h low=%h new=%b refill=%0d done=%b",
                             $time, want.out_high, want.out_low, want.is_new,
                             want.refill_stream, want.all_done);
                    $display("%0t:            actual high=%h low=%h new=%b refill=%0d done=%b",
                             $time, got.out_high, got.out_low, got.is_new,
                             got.refill_stream, got.all_done);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too many cycles without any transaction ends the run.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_merge.size());
            $display("kway_merge_dedup_core verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.active_streams = kmd_pkg::CFG_W'(kmd_pkg::STREAMS);
        item_bus.valid         = 1'b0;
        item_bus.stream        = '0;
        item_bus.key_high      = '0;
        item_bus.key_low       = '0;
        item_bus.stream_end    = 1'b0;
        result_bus.ready       = 1'b0;
        for (int s = 0; s < kmd_pkg::STREAMS; s++)
        begin
            head_key[s]      = '0;
            head_held[s]     = 1'b0;
            stream_closed[s] = 1'b0;
            stream_cursor[s] = '0;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_merge_basics();
        test_config_extremes();
        test_random_traffic();
        test_backpressure();
        test_completion();

        // drain, then allow for the registered result path
        item_bus.valid <= 1'b0;
        while (expected_merge.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (5) @(negedge clk);

        $display("Sent %0d items (%0d took effect), checked %0d results, %0d duplicates,",
                 items_sent, items_took, results_seen, dup_seen);
        $display("%0d completion marker(s), across eight register settings and four idle mixes.",
                 done_seen);
        if (errors == 0 && expected_merge.size() == 0)
        begin
            $display("kway_merge_dedup_core verification clean");
        end
        else
        begin
            $display("kway_merge_dedup_core verification failed");
        end
        $finish;
    end

endmodule

// File: kway_merge_dedup_core.f
src/kmd_pkg.sv
src/kmd_ifs.sv
src/kway_merge_dedup_core.sv
tb/kway_merge_dedup_core_tb.sv
